>>> rtl/masked_byte_pattern_scanner_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scanner
// Shorthand for the concurrent checks that sit at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBPS_ASSERT_HOLDS(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner check failed one cycle later");

`endif

>>> rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared widths, codes and types of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

   localparam int PATTERN_MAX_DEF = 64;

   localparam int BYTE_W        = 8;
   localparam int ADDR_W        = 32;
   localparam int LENGTH_W      = 7;
   localparam int ENTRY_INDEX_W = 6;
   localparam int REQ_TDATA_W   = 24;
   localparam int RSP_TDATA_W   = 32;
   localparam int CODE_W        = 2;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic [CODE_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_DATA  = 2'd2
   } op_type;

   typedef enum logic [CODE_W-1:0] {
      ST_NONE      = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_LENGTH = 2'd0,
      REG_BASE   = 2'd1,
      REG_OFFSET = 2'd2
   } reg_type;

   // Request tdata layout, lowest field last.
   typedef struct packed {
      logic                     pad;
      logic [BYTE_W-1:0]        data_byte;
      logic                     entry_care;
      logic [BYTE_W-1:0]        entry_value;
      logic [ENTRY_INDEX_W-1:0] entry_index;
   } req_data_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Finds the first window of a byte stream that matches a stored pattern
// with per-position wildcards and reports its address.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ stream. tuser carries the operation: load a
// pattern entry, start a scan, or a data byte (tlast marks the final byte of
// the region). Every accepted item yields exactly one transfer on the rsp_
// stream; tuser carries the status and tdata the match address.
// Load the pattern and write the registers over the csr_ port, send a start,
// then stream the region in address order.
// An item is taken in every cycle while req_tready is high, and its result
// is registered. The rate is set by the row of window cells, which shifts
// the history one byte per cycle and compares all positions at once against
// a pattern copy realigned on every load or length change.
// After a match or the end of a region, data bytes report nothing until the
// next start. Reset clears the window, the byte count and the report flag,
// and sets the length to one with zero base and offset; the pattern store
// holds no defined value until loaded.
// When rsp_tready is low, one more result is kept in a skid stage; after that
// req_tready drops until the receiver takes a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_scanner_macros.svh"

module masked_byte_pattern_scanner
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // tdata: entry_index[5:0], entry_value[13:6], entry_care[14],
   //        data_byte[22:15], zero[23]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: operation[1:0]
   input  wire logic [CODE_W-1:0]      req_tuser,
   input  wire logic                   req_tlast,
   // Result stream.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tdata: match_address[31:0]
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: status[1:0]
   output logic      [CODE_W-1:0]      rsp_tuser,
   // Configuration port.
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   req_data_type req_data;
   op_type       op;
   logic         accept;
   logic         is_load;
   logic         is_start;
   logic         is_data;
   cell_ctl_type cell_ctl;

   logic [LEN_W-1:0]  length_eff;
   logic [LEN_W-1:0]  length_next;
   logic [ADDR_W-1:0] addr_bias;

   logic [PATTERN_MAX-1:0][BYTE_W-1:0] aligned_byte;
   logic [PATTERN_MAX-1:0]             aligned_care;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0] neighbor;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0] window;
   logic [PATTERN_MAX-1:0]             hit;

   logic [ADDR_W-1:0] seen_ff;
   logic [ADDR_W-1:0] seen_in;
   logic [ADDR_W-1:0] seen_next;
   logic              done_ff;
   logic              done_in;
   logic              found;
   status_type        new_status;
   logic [ADDR_W-1:0] new_addr;

   logic              out_valid_ff;
   logic              out_valid_in;
   status_type        out_status_ff;
   status_type        out_status_in;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [ADDR_W-1:0] out_addr_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   status_type        skid_status_ff;
   status_type        skid_status_in;
   logic [ADDR_W-1:0] skid_addr_ff;
   logic [ADDR_W-1:0] skid_addr_in;
   logic              out_take;

   assign req_data = req_tdata;
   assign op       = op_type'(req_tuser);
   assign accept   = req_tvalid && req_tready;
   assign is_load  = accept && (op == OP_LOAD);
   assign is_start = accept && (op == OP_START);
   assign is_data  = accept && (op == OP_DATA) && !done_ff;

   assign cell_ctl.clear = is_start;
   assign cell_ctl.shift = is_data;

   mbps_csr #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .length_eff  (length_eff),
      .length_next (length_next),
      .addr_bias   (addr_bias)
   );

   mbps_align #(
      .PATTERN_MAX (PATTERN_MAX),
      .IDX_W       (IDX_W),
      .LEN_W       (LEN_W)
   ) u_align (
      .clock        (clock),
      .load_en      (is_load),
      .load_index   (req_data.entry_index),
      .load_value   (req_data.entry_value),
      .load_care    (req_data.entry_care),
      .length_next  (length_next),
      .aligned_byte (aligned_byte),
      .aligned_care (aligned_care)
   );

   // Cell 0 takes the newest byte; each later cell takes its neighbor's byte.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign neighbor[k] = req_data.data_byte;
      end else begin : g_body
         assign neighbor[k] = window[k-1];
      end
      mbps_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (cell_ctl),
         .neighbor_byte (neighbor[k]),
         .pattern_byte  (aligned_byte[k]),
         .pattern_care  (aligned_care[k]),
         .window_byte   (window[k]),
         .hit           (hit[k])
      );
   end

   assign seen_next = (seen_ff == '1) ? seen_ff : seen_ff + ADDR_W'(1);
   assign found     = (seen_next >= ADDR_W'(length_eff)) && (&hit);

   always_comb begin
      new_status = ST_NONE;
      new_addr   = '0;
      if (is_data) begin
         if (found) begin
            new_status = ST_FOUND;
            new_addr   = seen_next + addr_bias;
         end else if (req_tlast) begin
            new_status = ST_NOT_FOUND;
         end
      end
   end

   always_comb begin
      seen_in = seen_ff;
      done_in = done_ff;
      if (is_start) begin
         seen_in = '0;
         done_in = 1'b0;
      end else if (is_data) begin
         seen_in = seen_next;
         done_in = found || req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

   // Output register with a skid stage behind it.
   assign req_tready = !skid_valid_ff;
   assign out_take   = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_addr_in    = out_addr_ff;
      skid_valid_in  = skid_valid_ff;
      skid_status_in = skid_status_ff;
      skid_addr_in   = skid_addr_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_status_in = skid_status_ff;
            out_addr_in   = skid_addr_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = accept;
            out_status_in = new_status;
            out_addr_in   = new_addr;
         end
      end else if (accept) begin
         skid_valid_in  = 1'b1;
         skid_status_in = new_status;
         skid_addr_in   = new_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_status_ff  <= out_status_in;
      out_addr_ff    <= out_addr_in;
      skid_status_ff <= skid_status_in;
      skid_addr_ff   <= skid_addr_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = out_addr_ff;

   `MBPS_ASSERT_HOLDS(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `MBPS_ASSERT_NEXT(a_report_sets_done, clock, reset, accept && (new_status != ST_NONE), done_ff)
   `MBPS_ASSERT_HOLDS(a_quiet_after_report, clock, reset, accept && done_ff, new_status == ST_NONE)
   `MBPS_ASSERT_HOLDS(a_addr_only_on_match, clock, reset, rsp_tvalid && (rsp_tuser != ST_FOUND), rsp_tdata == '0)

endmodule

`default_nettype wire

>>> rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte of recent history, passes it on, and
// compares the byte it takes in against its aligned pattern entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell
   import mbps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_ctl_type      ctl,
   input  wire logic [BYTE_W-1:0] neighbor_byte,
   input  wire logic [BYTE_W-1:0] pattern_byte,
   input  wire logic              pattern_care,
   output logic      [BYTE_W-1:0] window_byte,
   output logic                   hit
);

   logic [BYTE_W-1:0] window_ff;
   logic [BYTE_W-1:0] window_in;

   always_comb begin
      window_in = window_ff;
      if (ctl.clear) begin
         window_in = '0;
      end else if (ctl.shift) begin
         window_in = neighbor_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // The hit refers to the byte this cell holds once the shift has happened.
   assign hit         = !pattern_care || (pattern_byte == neighbor_byte);
   assign window_byte = window_ff;

endmodule

`default_nettype wire

>>> rtl/mbps_align.sv
// ----------------------------------------------------------------------------
// mbps_align
// Pattern store plus a registered copy of it lined up with the window cells,
// so that cell k sees pattern entry length-1-k and a wildcard beyond length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_align
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int IDX_W       = 6,
   parameter int LEN_W       = 7
) (
   input  wire logic                     clock,
   input  wire logic                     load_en,
   input  wire logic [ENTRY_INDEX_W-1:0] load_index,
   input  wire logic [BYTE_W-1:0]        load_value,
   input  wire logic                     load_care,
   input  wire logic [LEN_W-1:0]         length_next,
   output logic [PATTERN_MAX-1:0][BYTE_W-1:0] aligned_byte,
   output logic [PATTERN_MAX-1:0]             aligned_care
);

   logic [BYTE_W-1:0] pat_ff  [PATTERN_MAX];
   logic [BYTE_W-1:0] pat_in  [PATTERN_MAX];
   logic              care_ff [PATTERN_MAX];
   logic              care_in [PATTERN_MAX];

   logic [PATTERN_MAX-1:0][BYTE_W-1:0] aligned_byte_ff;
   logic [PATTERN_MAX-1:0]             aligned_care_ff;

   logic [BYTE_W:0]    stage [IDX_W+1][PATTERN_MAX];
   logic [LEN_W-1:0]   gap;
   logic [IDX_W-1:0]   shift_amt;

   // A load beyond the store matches no entry and is dropped.
   always_comb begin
      for (int e = 0; e < PATTERN_MAX; e++) begin
         pat_in[e]  = pat_ff[e];
         care_in[e] = care_ff[e];
         if (load_en && (int'(load_index) == e)) begin
            pat_in[e]  = load_value;
            care_in[e] = load_care;
         end
      end
   end

   // Reverse the store, then shift it down by PATTERN_MAX - length with zero
   // fill; the zero care bits turn the unused positions into wildcards.
   always_comb begin
      gap       = LEN_W'(PATTERN_MAX) - length_next;
      shift_amt = gap[IDX_W-1:0];
      for (int k = 0; k < PATTERN_MAX; k++) begin
         stage[0][k] = {care_in[PATTERN_MAX-1-k], pat_in[PATTERN_MAX-1-k]};
      end
      for (int b = 0; b < IDX_W; b++) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            stage[b+1][k] = stage[b][k];
            if (shift_amt[b]) begin
               stage[b+1][k] = '0;
               if (k + (1 << b) < PATTERN_MAX) begin
                  stage[b+1][k] = stage[b][k + (1 << b)];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < PATTERN_MAX; e++) begin
         pat_ff[e]          <= pat_in[e];
         care_ff[e]         <= care_in[e];
         aligned_byte_ff[e] <= stage[IDX_W][e][BYTE_W-1:0];
         aligned_care_ff[e] <= stage[IDX_W][e][BYTE_W];
      end
   end

   assign aligned_byte = aligned_byte_ff;
   assign aligned_care = aligned_care_ff;

endmodule

`default_nettype wire

>>> rtl/mbps_csr.sv
// ----------------------------------------------------------------------------
// mbps_csr
// Configuration registers behind the APB-style port, with the clamped
// pattern length and the precomputed address bias.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_csr
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int LEN_W       = LENGTH_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [LEN_W-1:0]      length_eff,
   output logic      [LEN_W-1:0]      length_next,
   output logic      [ADDR_W-1:0]     addr_bias
);

   logic [LENGTH_W-1:0] length_ff;
   logic [LENGTH_W-1:0] length_in;
   logic [ADDR_W-1:0]   base_ff;
   logic [ADDR_W-1:0]   base_in;
   logic [ADDR_W-1:0]   offset_ff;
   logic [ADDR_W-1:0]   offset_in;
   logic [ADDR_W-1:0]   bias_ff;
   logic [ADDR_W-1:0]   bias_in;
   logic                wr_en;
   reg_type             reg_sel;

   function automatic logic [LEN_W-1:0] clamp_length(input logic [LENGTH_W-1:0] raw);
      logic [LEN_W-1:0] r;
      if (raw == '0) begin
         r = LEN_W'(1);
      end else if (int'(raw) > PATTERN_MAX) begin
         r = LEN_W'(PATTERN_MAX);
      end else begin
         r = LEN_W'(raw);
      end
      return r;
   endfunction

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      length_in = length_ff;
      base_in   = base_ff;
      offset_in = offset_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LENGTH: length_in = pwdata[LENGTH_W-1:0];
            REG_BASE:   base_in   = pwdata[ADDR_W-1:0];
            REG_OFFSET: offset_in = pwdata[ADDR_W-1:0];
            default:    length_in = length_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LENGTH: prdata = CSR_DATA_W'(length_ff);
         REG_BASE:   prdata = CSR_DATA_W'(base_ff);
         REG_OFFSET: prdata = CSR_DATA_W'(offset_ff);
         default:    prdata = '0;
      endcase
   end

   assign length_eff  = clamp_length(length_ff);
   assign length_next = clamp_length(length_in);

   // A match address is the saturated byte count plus this bias.
   assign bias_in = base_in + offset_in - ADDR_W'(length_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_W'(1);
         base_ff   <= '0;
         offset_ff <= '0;
         // Zero base and offset less a length of one.
         bias_ff   <= '1;
      end else begin
         length_ff <= length_in;
         base_ff   <= base_in;
         offset_ff <= offset_in;
         bias_ff   <= bias_in;
      end
   end

   assign addr_bias = bias_ff;

endmodule

`default_nettype wire

>>> sim/masked_byte_pattern_scanner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_checker
// Watches the request, result and configuration ports of the scanner. It
// keeps its own copy of the pattern, the byte history and the registers,
// works out the result of every accepted request and compares each result
// transfer with the oldest outstanding prediction. Register reads are
// checked against the shadow copies.
// ----------------------------------------------------------------------------

module masked_byte_pattern_scanner_checker
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [CODE_W-1:0]      req_tuser,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [CODE_W-1:0]      rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [CSR_DATA_W-1:0]  csr_prdata,
   input  logic                   csr_pready,
   output int unsigned            fail_count,
   output int unsigned            pending
);

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] address;
   } scan_result_type;

   logic [BYTE_W-1:0]   pattern_value [PATTERN_MAX];
   logic                pattern_care  [PATTERN_MAX];
   // history[k] is the byte k positions before the newest one.
   logic [BYTE_W-1:0]   history       [PATTERN_MAX];
   logic [ADDR_W-1:0]   bytes_taken;
   logic                reported;
   logic [LENGTH_W-1:0] length_reg;
   logic [ADDR_W-1:0]   base_reg;
   logic [ADDR_W-1:0]   offset_reg;
   scan_result_type     result_queue [$];
   int unsigned         errors = 0;

   function automatic int unsigned used_length();
      if (length_reg == '0) return 1;
      if (int'(length_reg) > PATTERN_MAX) return PATTERN_MAX;
      return int'(length_reg);
   endfunction

   function automatic bit window_hit(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if (pattern_care[i] && pattern_value[i] != history[n - 1 - i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic scan_result_type scan_step(logic [CODE_W-1:0] op, req_data_type f,
                                                 logic last);
      scan_result_type r;
      int unsigned     n;
      r.status  = ST_NONE;
      r.address = '0;
      case (op)
         OP_LOAD: begin
            if (int'(f.entry_index) < PATTERN_MAX) begin
               pattern_value[f.entry_index] = f.entry_value;
               pattern_care[f.entry_index]  = f.entry_care;
            end
         end
         OP_START: begin
            for (int k = 0; k < PATTERN_MAX; k++) history[k] = '0;
            bytes_taken = '0;
            reported    = 1'b0;
         end
         OP_DATA: begin
            if (!reported) begin
               n = used_length();
               for (int k = PATTERN_MAX - 1; k > 0; k--) history[k] = history[k - 1];
               history[0] = f.data_byte;
               if (bytes_taken != '1) bytes_taken++;
               if (bytes_taken >= ADDR_W'(n) && window_hit(n)) begin
                  r.status  = ST_FOUND;
                  r.address = base_reg + (bytes_taken - ADDR_W'(n)) + offset_reg;
                  reported  = 1'b1;
               end else if (last) begin
                  r.status = ST_NOT_FOUND;
                  reported = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      scan_result_type       want;
      scan_result_type       fresh;
      logic [CSR_DATA_W-1:0] reg_value;
      if (reset) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            history[k]       = '0;
            pattern_value[k] = '0;
            pattern_care[k]  = 1'b0;
         end
         bytes_taken = '0;
         reported    = 1'b0;
         length_reg  = LENGTH_W'(1);
         base_reg    = '0;
         offset_reg  = '0;
         result_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing expected, status %0d address %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = result_queue.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata !== want.address) begin
                  errors++;
                  $display("%0t: expected status %0d address %h, got status %0d address %h",
                           $time, want.status, want.address, rsp_tuser, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fresh        = scan_step(req_tuser, req_data_type'(req_tdata), req_tlast);
            result_queue = {result_queue, fresh};
         end
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_paddr)
               {REG_LENGTH, 2'b00}: reg_value = CSR_DATA_W'(length_reg);
               {REG_BASE, 2'b00}:   reg_value = base_reg;
               {REG_OFFSET, 2'b00}: reg_value = offset_reg;
               default:             reg_value = '0;
            endcase
            if (csr_pwrite) begin
               case (csr_paddr)
                  {REG_LENGTH, 2'b00}: length_reg = csr_pwdata[LENGTH_W-1:0];
                  {REG_BASE, 2'b00}:   base_reg   = csr_pwdata;
                  {REG_OFFSET, 2'b00}: offset_reg = csr_pwdata;
                  default: ;
               endcase
            end else if (csr_prdata !== reg_value) begin
               errors++;
               $display("%0t: register read at %h expected %h, got %h",
                        $time, csr_paddr, reg_value, csr_prdata);
            end
         end
      end
      fail_count <= errors;
      pending    <= result_queue.size();
   end

endmodule

>>> sim/masked_byte_pattern_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb
// Drives the scanner with a short directed sequence and then with random
// scan regions, most of them holding a planted copy of the pattern, under
// random gaps on both streams, a long result back-pressure and a stretch
// with no gaps. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module masked_byte_pattern_scanner_tb;
   import mbps_pkg::*;

   localparam int                WATCHDOG_LIMIT = 1000;
   localparam int                TARGET_ITEMS   = 800;
   localparam int                HOLD_CYCLES    = 80;
   localparam logic [CODE_W-1:0] OP_UNUSED      = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [CODE_W-1:0]      req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [CODE_W-1:0]      rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned idle_cycles = 0;
   int unsigned items_sent  = 0;
   int unsigned hold_asks   = 0;
   int unsigned scan_length = 1;
   bit          no_gaps     = 1'b0;

   // What has been loaded so far, used to plant matches in the byte stream.
   logic [BYTE_W-1:0] plan_value [PATTERN_MAX_DEF];
   logic              plan_care  [PATTERN_MAX_DEF];

   always #1 clock = ~clock;

   masked_byte_pattern_scanner u_top (.*);

   masked_byte_pattern_scanner_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Result side: random stalls, a long hold-off on request, none while
   // the stimulus asks for a stretch without gaps.
   initial begin : receiver
      int unsigned hold_served;
      hold_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= no_gaps || ($urandom_range(99) >= 18);
      end
   end

   function automatic req_data_type noise_fields();
      req_data_type f;
      f = {1'b0, 23'($urandom)};
      return f;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [LENGTH_W-1:0] pick_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return LENGTH_W'($urandom_range(1, 6));
      if (roll < 85) return LENGTH_W'($urandom_range(7, 20));
      if (roll < 93) return LENGTH_W'($urandom_range(21, 64));
      return LENGTH_W'($urandom_range(65, 127));
   endfunction

   // Called in the step of a rising edge; returns in the step of the
   // edge at which the transfer took place.
   task automatic send_item(input logic [CODE_W-1:0] op, input req_data_type f,
                            input logic last);
      if (!no_gaps && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      f.pad = 1'b0;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= f;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic load_entry(input logic [ENTRY_INDEX_W-1:0] index,
                             input logic [BYTE_W-1:0] value, input logic care);
      req_data_type f;
      f = noise_fields();
      f.entry_index = index;
      f.entry_value = value;
      f.entry_care  = care;
      plan_value[index] = value;
      plan_care[index]  = care;
      send_item(OP_LOAD, f, 1'($urandom_range(1)));
   endtask

   task automatic start_scan();
      send_item(OP_START, noise_fields(), 1'($urandom_range(1)));
   endtask

   task automatic data_byte(input logic [BYTE_W-1:0] value, input logic last);
      req_data_type f;
      f = noise_fields();
      f.data_byte = value;
      send_item(OP_DATA, f, last);
   endtask

   // Drops valid and waits until every outstanding result has been taken.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_access(input reg_type which, input bit write_op,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_op;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (write_op && which == REG_LENGTH) begin
         if (value[LENGTH_W-1:0] == '0) scan_length = 1;
         else if (value[LENGTH_W-1:0] > PATTERN_MAX_DEF) scan_length = PATTERN_MAX_DEF;
         else scan_length = 32'(value[LENGTH_W-1:0]);
      end
   endtask

   task automatic read_settings();
      csr_access(REG_LENGTH, 1'b0, '0);
      csr_access(REG_BASE, 1'b0, '0);
      csr_access(REG_OFFSET, 1'b0, '0);
   endtask

   task automatic write_settings(input logic [LENGTH_W-1:0] length,
                                 input logic [31:0] base, input logic [31:0] offset);
      csr_access(REG_LENGTH, 1'b1, CSR_DATA_W'(length));
      csr_access(REG_BASE, 1'b1, base);
      csr_access(REG_OFFSET, 1'b1, offset);
      read_settings();
   endtask

   // Streams one region; with plant set, a copy of the pattern sits at a
   // random place, wildcard positions keeping their random byte.
   task automatic scan_region(input int unsigned n, input bit plant);
      int unsigned       spot;
      logic [BYTE_W-1:0] value;
      spot = (n >= scan_length) ? $urandom_range(n - scan_length) : 0;
      for (int unsigned i = 0; i < n; i++) begin
         value = BYTE_W'($urandom_range(255));
         if (plant && n >= scan_length && i >= spot && i < spot + scan_length &&
             plan_care[i - spot])
            value = plan_value[i - spot];
         data_byte(value, i == n - 1);
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned regions;
      int unsigned roll;
      int unsigned n;
      for (int k = 0; k < PATTERN_MAX_DEF; k++) begin
         plan_value[k] = '0;
         plan_care[k]  = 1'b0;
      end
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_LOAD;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values, then data with no start, a hit of a one-byte pattern,
      // a byte after the report and an unknown operation.
      read_settings();
      load_entry(0, 8'hA5, 1'b1);
      data_byte(8'h00, 1'b0);
      data_byte(8'hA5, 1'b0);
      data_byte(8'hA5, 1'b0);
      send_item(OP_UNUSED, noise_fields(), 1'b0);
      settle();

      // Address arithmetic wraps; a wildcard in the pattern; match on the
      // last byte, a region shorter than the pattern and a plain miss.
      write_settings(LENGTH_W'(4), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      load_entry(1, 8'h00, 1'b0);
      load_entry(2, 8'hFF, 1'b1);
      load_entry(3, 8'h3C, 1'b1);
      load_entry(63, 8'hFF, 1'b0);
      start_scan();
      data_byte(8'h11, 1'b0);
      data_byte(8'hA5, 1'b0);
      data_byte(8'h77, 1'b0);
      data_byte(8'hFF, 1'b0);
      data_byte(8'h3C, 1'b1);
      start_scan();
      data_byte(8'hA5, 1'b0);
      data_byte(8'h00, 1'b1);
      start_scan();
      repeat (4) data_byte(8'h00, 1'b0);
      data_byte(8'hFF, 1'b1);

      // Every pattern position gets written before the random part.
      for (int k = 0; k < PATTERN_MAX_DEF; k++)
         load_entry(ENTRY_INDEX_W'(k), BYTE_W'($urandom_range(255)),
                    $urandom_range(99) < 75);

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         settle();
         case (phase)
            0:       write_settings(7'h7F, 32'h0000_0000, 32'hFFFF_FFFF);
            1:       write_settings(7'h00, 32'hFFFF_FFFF, 32'h0000_0000);
            2:       write_settings(LENGTH_W'(PATTERN_MAX_DEF), pick_word(), pick_word());
            default: write_settings(pick_length(), pick_word(), pick_word());
         endcase
         no_gaps = (phase == 1);
         if (phase == 1) regions = 12;
         else if (scan_length > 20) regions = 3;
         else regions = $urandom_range(3, 6);
         for (int unsigned r = 0; r < regions; r++) begin
            // The result side stalls for a long time while requests go on.
            if (phase == 0 && r == 1) hold_asks++;
            roll = $urandom_range(99);
            if (roll < 10) begin
               repeat ($urandom_range(1, 3))
                  load_entry(ENTRY_INDEX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)),
                             $urandom_range(99) < 75);
            end else if (roll < 15) begin
               send_item(OP_UNUSED, noise_fields(), 1'($urandom_range(1)));
            end
            if ($urandom_range(99) < 92) start_scan();
            if ($urandom_range(99) < 15) n = $urandom_range(1, scan_length);
            else n = scan_length + $urandom_range(0, 12);
            scan_region(n, $urandom_range(99) < 70);
            // Bytes after a report are ignored until the next start.
            if ($urandom_range(99) < 15)
               data_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
         end
         no_gaps = 1'b0;
         phase++;
      end

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/mbps_align.sv
rtl/mbps_csr.sv
rtl/masked_byte_pattern_scanner.sv
sim/masked_byte_pattern_scanner_checker.sv
sim/masked_byte_pattern_scanner_tb.sv
